// ===== hw/rtl/ale_pkg.sv =====
package ale_pkg;

    localparam int CAPACITY = 64;
    localparam int ITEM_W   = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ITEM_W-1:0] t_item;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_SEARCH     = 3'd2,
        OP_READ       = 3'd3,
        OP_ITER_FIRST = 3'd4,
        OP_ITER_NEXT  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] out_value;
        logic [INDEX_W-1:0]        out_index;
        logic [COUNT_W-1:0]        count;
    } t_result;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_item data;
    } t_mem_wr;

endpackage

// ===== hw/rtl/ale_if.sv =====
interface ale_in_if;
    logic                                valid;
    logic                                ready;
    logic [ale_pkg::OP_W-1:0]            op;
    logic signed [ale_pkg::VALUE_W-1:0]  value;
    logic [ale_pkg::INDEX_W-1:0]         index;

    modport source (output valid, op, value, index, input ready);
    modport sink   (input valid, op, value, index, output ready);
endinterface

interface ale_out_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [ale_pkg::VALUE_W-1:0]  out_value;
    logic [ale_pkg::INDEX_W-1:0]         out_index;
    logic [ale_pkg::COUNT_W-1:0]         count;

    modport source (output valid, ok, out_value, out_index, count, input ready);
    modport sink   (input valid, ok, out_value, out_index, count, output ready);
endinterface

// ===== hw/rtl/ale_ram.sv =====
module ale_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ale_ctrl.sv =====
module ale_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ale_in_if.sink             i_in,
    output ale_pkg::t_result   o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output ale_pkg::t_mem_wr   o_mem_wr,
    output ale_pkg::t_addr     o_mem_raddr,
    input  ale_pkg::t_item     i_mem_rdata
);

    ale_pkg::t_state  r_state, n_state;
    ale_pkg::t_cnt    r_fill,  n_fill;
    ale_pkg::t_cnt    r_iter,  n_iter;
    ale_pkg::t_cnt    r_ptr,   n_ptr;
    logic             r_pend,  n_pend;
    ale_pkg::t_addr   r_cidx,  n_cidx;
    ale_pkg::t_item   r_val,   n_val;
    logic             r_rm,    n_rm;
    ale_pkg::t_result r_res,   n_res;

    logic             issue;
    logic             match;
    ale_pkg::t_cnt    it_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ale_pkg::S_IDLE;
            r_fill  <= '0;
            r_iter  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_iter  <= n_iter;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_cidx <= n_cidx;
        r_val  <= n_val;
        r_rm   <= n_rm;
        r_res  <= n_res;
    end

    // scan/shift walk: r_ptr is the next address to read, r_cidx the entry now on the read port
    assign issue = (r_ptr < r_fill);
    assign match = r_pend && (i_mem_rdata == r_val);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_iter      = r_iter;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_cidx      = r_cidx;
        n_val       = r_val;
        n_rm        = r_rm;
        n_res       = r_res;
        o_mem_wr    = '0;
        o_mem_raddr = r_ptr[ale_pkg::ADDR_W-1:0];
        o_res_valid = 1'b0;
        i_in.ready  = 1'b0;
        it_pos      = '0;

        case (r_state)
            ale_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_res   = '0;
                    n_state = ale_pkg::S_DONE;
                    case (ale_pkg::t_op'(i_in.op))
                        ale_pkg::OP_APPEND: begin
                            if (32'(r_fill) < ale_pkg::CAPACITY) begin
                                o_mem_wr.en   = 1'b1;
                                o_mem_wr.addr = r_fill[ale_pkg::ADDR_W-1:0];
                                o_mem_wr.data = i_in.value[ale_pkg::ITEM_W-1:0];
                                n_fill        = ale_pkg::t_cnt'(r_fill + 1'b1);
                                n_res.ok      = 1'b1;
                            end
                        end
                        ale_pkg::OP_REMOVE, ale_pkg::OP_SEARCH: begin
                            n_val = i_in.value[ale_pkg::ITEM_W-1:0];
                            n_rm  = (ale_pkg::t_op'(i_in.op) == ale_pkg::OP_REMOVE);
                            n_ptr = '0;
                            if (r_fill != '0) begin
                                n_state = ale_pkg::S_SCAN;
                            end
                        end
                        ale_pkg::OP_READ: begin
                            o_mem_raddr = ale_pkg::t_addr'(i_in.index);
                            if (32'(i_in.index) < 32'(r_fill)) begin
                                n_state = ale_pkg::S_READ;
                            end
                        end
                        ale_pkg::OP_ITER_FIRST, ale_pkg::OP_ITER_NEXT: begin
                            it_pos = (ale_pkg::t_op'(i_in.op) == ale_pkg::OP_ITER_FIRST)
                                     ? '0 : r_iter;
                            o_mem_raddr = it_pos[ale_pkg::ADDR_W-1:0];
                            if (it_pos < r_fill) begin
                                n_iter  = ale_pkg::t_cnt'(it_pos + 1'b1);
                                n_state = ale_pkg::S_READ;
                            end else begin
                                n_iter = r_fill;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.count = ale_pkg::COUNT_W'(n_fill);
                end
            end

            ale_pkg::S_SCAN: begin
                n_pend = issue;
                n_cidx = r_ptr[ale_pkg::ADDR_W-1:0];
                n_ptr  = issue ? ale_pkg::t_cnt'(r_ptr + 1'b1) : r_ptr;
                if (match) begin
                    n_res.ok        = 1'b1;
                    n_res.out_index = ale_pkg::INDEX_W'(r_cidx);
                    // remove continues with the read of the following entry already issued
                    n_state = r_rm ? ale_pkg::S_SHIFT : ale_pkg::S_DONE;
                end else if (r_pend && !issue) begin
                    n_state = ale_pkg::S_DONE;
                end
            end

            ale_pkg::S_SHIFT: begin
                n_pend = issue;
                n_cidx = r_ptr[ale_pkg::ADDR_W-1:0];
                n_ptr  = issue ? ale_pkg::t_cnt'(r_ptr + 1'b1) : r_ptr;
                if (r_pend) begin
                    o_mem_wr.en   = 1'b1;
                    o_mem_wr.addr = ale_pkg::t_addr'(r_cidx - 1'b1);
                    o_mem_wr.data = i_mem_rdata;
                end else begin
                    n_fill      = ale_pkg::t_cnt'(r_fill - 1'b1);
                    n_res.count = ale_pkg::COUNT_W'(n_fill);
                    n_state     = ale_pkg::S_DONE;
                end
            end

            ale_pkg::S_READ: begin
                n_res.ok        = 1'b1;
                n_res.out_value = ale_pkg::VALUE_W'(i_mem_rdata);
                n_state         = ale_pkg::S_DONE;
            end

            ale_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ale_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ale_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/array_list_engine_unit.sv =====
// Search walks the list through the RAM read port, one entry per cycle; remove adds a shift
// pass, one entry per cycle, to the end. One item in flight: the next beat is taken once the
// result has left the engine for the output register, so a new beat is taken while the
// previous result waits.
// Reset: count and iterator cleared; list contents are not cleared and never read unwritten.
module array_list_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_in_if.sink    i_in,
    ale_out_if.source o_out
);

    ale_pkg::t_result  res;
    logic              res_valid;
    logic              res_ready;
    ale_pkg::t_mem_wr  mem_wr;
    ale_pkg::t_addr    mem_raddr;
    ale_pkg::t_item    mem_rdata;

    logic              r_out_valid;
    ale_pkg::t_result  r_out;

    ale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_mem_wr    (mem_wr),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ale_ram #(
        .DEPTH (ale_pkg::CAPACITY),
        .WIDTH (ale_pkg::ITEM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_wr.en),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register: frees the engine while a result beat waits for the sink
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.ok        = r_out.ok;
    assign o_out.out_value = r_out.out_value;
    assign o_out.out_index = r_out.out_index;
    assign o_out.count     = r_out.count;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in flight");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |-> (o_out.out_value == '0 && o_out.out_index == '0))
        else $error("failed result carries nonzero value or index");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.count) <= ale_pkg::CAPACITY))
        else $error("count beyond capacity");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [ale_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [ale_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * ale_pkg::CAPACITY + 20;

    typedef enum int {
        MODE_GROW,
        MODE_MIX,
        MODE_SHRINK
    } t_mode;

    class list_scoreboard;
        ale_pkg::t_item   store [ale_pkg::CAPACITY];
        int unsigned      fill;
        int unsigned      iter_pos;
        ale_pkg::t_result expected_q [$];
        int unsigned      accepted;
        int unsigned      errors;

        function int find_first(ale_pkg::t_item v);
            for (int i = 0; i < fill; i++) begin
                if (store[i] == v) return i;
            end
            return -1;
        endfunction

        // Predict the result of one accepted beat and queue it.
        function void note_item(logic [ale_pkg::OP_W-1:0] op,
                                logic [ale_pkg::VALUE_W-1:0] value,
                                logic [ale_pkg::INDEX_W-1:0] index);
            ale_pkg::t_result r;
            ale_pkg::t_item   v;
            int               pos;
            r = '0;
            v = value[ale_pkg::ITEM_W-1:0];
            accepted++;
            case (op)
                ale_pkg::OP_APPEND: begin
                    if (fill < ale_pkg::CAPACITY) begin
                        store[fill] = v;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                ale_pkg::OP_REMOVE: begin
                    pos = find_first(v);
                    if (pos >= 0) begin
                        for (int i = pos; i + 1 < fill; i++) store[i] = store[i + 1];
                        fill--;
                        r.ok        = 1'b1;
                        r.out_index = pos[ale_pkg::INDEX_W-1:0];
                    end
                end
                ale_pkg::OP_SEARCH: begin
                    pos = find_first(v);
                    if (pos >= 0) begin
                        r.ok        = 1'b1;
                        r.out_index = pos[ale_pkg::INDEX_W-1:0];
                    end
                end
                ale_pkg::OP_READ: begin
                    if (index < fill) begin
                        r.ok        = 1'b1;
                        r.out_value = store[index];
                    end
                end
                ale_pkg::OP_ITER_FIRST, ale_pkg::OP_ITER_NEXT: begin
                    if (op == ale_pkg::OP_ITER_FIRST) iter_pos = 0;
                    if (iter_pos < fill) begin
                        r.ok        = 1'b1;
                        r.out_value = store[iter_pos];
                        iter_pos++;
                    end else begin
                        // saturate so a later append is picked up by the next step
                        iter_pos = fill;
                    end
                end
                default: ;
            endcase
            r.count = fill[ale_pkg::COUNT_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(ale_pkg::t_result got);
            ale_pkg::t_result exp;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: ok=%0d value=%0h index=%0d count=%0d",
                       got.ok, got.out_value, got.out_index, got.count);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.ok !== exp.ok) begin
                $error("ok: expected %0d, actual %0d", exp.ok, got.ok);
                errors++;
            end
            if (got.out_value !== exp.out_value) begin
                $error("out_value: expected %0h, actual %0h", exp.out_value, got.out_value);
                errors++;
            end
            if (got.out_index !== exp.out_index) begin
                $error("out_index: expected %0d, actual %0d", exp.out_index, got.out_index);
                errors++;
            end
            if (got.count !== exp.count) begin
                $error("count: expected %0d, actual %0d", exp.count, got.count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function ale_pkg::t_item pick_entry();
            return store[$urandom_range(fill - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ale_in_if  in_bus ();
    ale_out_if out_bus ();

    array_list_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    list_scoreboard sb = new();

    int unsigned burst_left = 0;
    bit          no_gaps    = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1500000;
        $display("Simulation FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(logic [ale_pkg::OP_W-1:0] op, logic [ale_pkg::VALUE_W-1:0] value,
                             logic [ale_pkg::INDEX_W-1:0] index);
        in_bus.valid <= 1'b1;
        in_bus.op    <= op;
        in_bus.value <= value;
        in_bus.index <= index;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_item(op, value, index);
        @(negedge i_clk);
    endtask

    task automatic offer_item(logic [ale_pkg::OP_W-1:0] op, logic [ale_pkg::VALUE_W-1:0] value,
                              logic [ale_pkg::INDEX_W-1:0] index);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(op, value, index);
    endtask

    function automatic logic [ale_pkg::OP_W-1:0] choose_op(t_mode mode);
        int unsigned r;
        int unsigned append_w;
        int unsigned remove_w;
        r = $urandom_range(99);
        case (mode)
            MODE_GROW:   begin append_w = 80; remove_w = 5;  end
            MODE_SHRINK: begin append_w = 10; remove_w = 60; end
            default:     begin append_w = 30; remove_w = 25; end
        endcase
        if (r < append_w) return ale_pkg::OP_APPEND;
        if (r < append_w + remove_w) return ale_pkg::OP_REMOVE;
        if (r >= 98) return ($urandom_range(1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
        case ($urandom_range(4))
            0:       return ale_pkg::OP_SEARCH;
            1:       return ale_pkg::OP_READ;
            2:       return ale_pkg::OP_ITER_FIRST;
            default: return ale_pkg::OP_ITER_NEXT;
        endcase
    endfunction

    // Half the time a value already in the list (when it is not empty), so remove and search hit.
    function automatic logic [ale_pkg::VALUE_W-1:0] choose_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50 && sb.fill > 0) return sb.pick_entry();
        if (r < 75) begin
            case ($urandom_range(5))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return $urandom_range(15);
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [ale_pkg::INDEX_W-1:0] choose_index();
        if (sb.fill > 0 && $urandom_range(3) != 0)
            return ale_pkg::INDEX_W'($urandom_range(sb.fill - 1));
        return ale_pkg::INDEX_W'($urandom_range(63));
    endfunction

    task automatic run_directed();
        send_item(ale_pkg::OP_READ,       32'd0,          6'd0);
        send_item(ale_pkg::OP_ITER_FIRST, 32'd0,          6'd0);
        send_item(ale_pkg::OP_ITER_NEXT,  32'd0,          6'd0);
        send_item(ale_pkg::OP_SEARCH,     32'd5,          6'd0);
        send_item(ale_pkg::OP_REMOVE,     32'd5,          6'd0);
        send_item(OP_UNUSED_6,            32'hdead_beef,  6'd63);
        send_item(ale_pkg::OP_APPEND,     32'h8000_0000,  6'd0);
        // iterator sat at zero on the empty list, so it now yields the new entry
        send_item(ale_pkg::OP_ITER_NEXT,  32'd0,          6'd0);
        send_item(ale_pkg::OP_APPEND,     32'h7fff_ffff,  6'd63);
        send_item(ale_pkg::OP_APPEND,     32'h0000_0000,  6'd0);
        send_item(ale_pkg::OP_APPEND,     32'hffff_ffff,  6'd0);
        send_item(ale_pkg::OP_APPEND,     32'h7fff_ffff,  6'd0);
        send_item(ale_pkg::OP_SEARCH,     32'h7fff_ffff,  6'd0);
        send_item(ale_pkg::OP_READ,       32'd0,          6'd3);
        send_item(ale_pkg::OP_READ,       32'd0,          6'd63);
        send_item(ale_pkg::OP_READ,       32'd0,          6'd5);
        send_item(ale_pkg::OP_ITER_FIRST, 32'd0,          6'd0);
        send_item(ale_pkg::OP_ITER_NEXT,  32'd0,          6'd0);
        send_item(ale_pkg::OP_REMOVE,     32'h7fff_ffff,  6'd0);
        send_item(ale_pkg::OP_REMOVE,     32'h7fff_ffff,  6'd0);
        send_item(ale_pkg::OP_REMOVE,     32'h8000_0000,  6'd0);
        send_item(ale_pkg::OP_SEARCH,     32'h1234_5678,  6'd0);
        send_item(OP_UNUSED_7,            32'hffff_ffff,  6'd42);
        send_item(ale_pkg::OP_ITER_NEXT,  32'd0,          6'd0);
        send_item(ale_pkg::OP_READ,       32'd0,          6'd1);
    endtask

    task automatic run_random();
        int unsigned sent;
        int unsigned seg;
        int unsigned seg_len;
        t_mode       mode;
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            case (seg % 4)
                0:       mode = MODE_GROW;
                2:       mode = MODE_SHRINK;
                default: mode = MODE_MIX;
            endcase
            no_gaps = ($urandom_range(4) == 0);
            seg_len = $urandom_range(80, 140);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                offer_item(choose_op(mode), choose_value(), choose_index());
                sent++;
            end
            seg++;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        in_bus.valid  <= 1'b0;
        in_bus.op     <= ale_pkg::OP_APPEND;
        in_bus.value  <= '0;
        in_bus.index  <= '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        run_random();
        in_bus.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stall modes, plus one long hold-off while input keeps coming.
    initial begin
        int unsigned win;
        int unsigned rx_mode;
        logic [7:0]  rx_pattern;
        bit          held;
        win        = 0;
        rx_mode    = 0;
        rx_pattern = 8'hff;
        held       = 0;
        out_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && sb.accepted >= HOLD_AT_ITEM) begin
                held = 1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (win == 0) begin
                    rx_mode    = $urandom_range(3);
                    rx_pattern = 8'($urandom);
                    win        = $urandom_range(20, 80);
                end
                win--;
                case (rx_mode)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= 1'($urandom_range(1));
                    2: out_bus.ready <= ($urandom_range(3) == 0);
                    default: begin
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                        out_bus.ready <= rx_pattern[0];
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            sb.check_result('{ok: out_bus.ok, out_value: out_bus.out_value,
                              out_index: out_bus.out_index, count: out_bus.count});
    end

endmodule

// ===== array_list_engine_unit.f =====
hw/rtl/ale_pkg.sv
hw/rtl/ale_if.sv
hw/rtl/ale_ram.sv
hw/rtl/ale_ctrl.sv
hw/rtl/array_list_engine_unit.sv
tb/testbench.sv
